// ----- rtl/core/htwd_pkg.sv -----
package htwd_pkg;

  localparam int IDX_BITS   = 9;
  localparam int SYM_BITS   = 8;
  localparam int COUNT_BITS = 16;

  localparam logic [IDX_BITS-1:0] ROOT_RESET = 9'd510;
  localparam logic [IDX_BITS-1:0] LEAF_RESET = 9'd256;

  // result queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;
  localparam int QCNT_BITS = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [0:0] {
    REG_ROOT_INDEX = 1'b0,
    REG_LEAF_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                command;
    logic [IDX_BITS-1:0] node_index;
    logic [IDX_BITS-1:0] left_child;
    logic [IDX_BITS-1:0] right_child;
    logic [SYM_BITS-1:0] node_symbol;
    logic                code_bit;
    logic                end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]   symbol;
    logic                  symbol_valid;
    logic [COUNT_BITS-1:0] symbol_count;
    logic                  stream_done;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] left_child;
    logic [IDX_BITS-1:0] right_child;
    logic [SYM_BITS-1:0] node_symbol;
  } node_wr_t;

  typedef struct packed {
    logic b_busy;
    logic c_busy;
  } pipe_status_t;

endpackage

// ----- rtl/core/huffman_tree_walk_decoder.sv -----
// Tree-walk decoder for a Huffman bit stream.
// in channel: one beat is either a node write (command 0: node_index,
// children and symbol go into the node table) or one code bit (command 1,
// with end_of_stream marking the last bit of a stream).
// out channel: one beat per decoded symbol or end-of-stream bit (one beat
// when both meet), carrying the symbol, its valid flag, the saturating count
// and a done flag.
// cfg channel: index 0 sets root_index, index 1 sets leaf_count; always
// ready, to be written only while the decoder is idle.
// A bit's result passes stage b, stage c and the result queue before it
// raises out_valid.
// Throughput: one item per cycle while in_ready is high; the next bit's
// table read takes its address straight from the child entry read of the
// bit before, so the walk loop is one synchronous memory read.
// A four-beat result queue absorbs a stalled receiver; in_ready drops when
// the queue plus the results still in the pipeline could fill it.
// Reset clears the walk, the count and the queue and restores root_index to
// 510 and leaf_count to 256; the node table keeps no reset value and must
// be written before it is walked.
module huffman_tree_walk_decoder #(
  parameter int NODE_SLOTS = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  htwd_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output htwd_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  htwd_pkg::cfg_reg_t            cfg_index,
  input  logic [htwd_pkg::IDX_BITS-1:0] cfg_data
);
  import htwd_pkg::*;

  logic [IDX_BITS-1:0] root_index;
  logic [IDX_BITS-1:0] leaf_count;

  node_wr_t            wr;
  logic [IDX_BITS-1:0] child_raddr;
  logic [IDX_BITS-1:0] sym_raddr;
  logic [IDX_BITS-1:0] child_left;
  logic [IDX_BITS-1:0] child_right;
  logic [SYM_BITS-1:0] leaf_sym;
  logic                push;
  out_item_t           push_item;
  pipe_status_t        status;
  logic [QCNT_BITS-1:0] q_count;
  logic                in_beat;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;
  assign in_ready  = (q_count + QCNT_BITS'(status.b_busy) + QCNT_BITS'(status.c_busy))
                     < QCNT_BITS'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_index <= ROOT_RESET;
      leaf_count <= LEAF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROOT_INDEX: root_index <= cfg_data;
        REG_LEAF_COUNT: leaf_count <= cfg_data;
        default: ;
      endcase
    end
  end

  htwd_node_mem #(
    .NODE_SLOTS (NODE_SLOTS)
  ) u_node_mem (
    .clk         (clk),
    .wr          (wr),
    .child_raddr (child_raddr),
    .sym_raddr   (sym_raddr),
    .child_left  (child_left),
    .child_right (child_right),
    .leaf_sym    (leaf_sym)
  );

  htwd_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_beat     (in_beat),
    .in_item     (in_item),
    .root_index  (root_index),
    .leaf_count  (leaf_count),
    .child_left  (child_left),
    .child_right (child_right),
    .leaf_sym    (leaf_sym),
    .wr          (wr),
    .child_raddr (child_raddr),
    .sym_raddr   (sym_raddr),
    .push        (push),
    .push_item   (push_item),
    .status      (status)
  );

  htwd_result_q u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .count     (q_count)
  );

endmodule

// ----- rtl/core/htwd_node_mem.sv -----
module htwd_node_mem #(
  parameter int NODE_SLOTS = 512
) (
  input  logic                      clk,
  input  htwd_pkg::node_wr_t        wr,
  input  logic [htwd_pkg::IDX_BITS-1:0] child_raddr,
  input  logic [htwd_pkg::IDX_BITS-1:0] sym_raddr,
  output logic [htwd_pkg::IDX_BITS-1:0] child_left,
  output logic [htwd_pkg::IDX_BITS-1:0] child_right,
  output logic [htwd_pkg::SYM_BITS-1:0] leaf_sym
);
  import htwd_pkg::*;

  // slots above the index range can never be reached
  localparam int DEPTH = (NODE_SLOTS > 512) ? 512 : NODE_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_BITS:0] DEPTH_LIM = (IDX_BITS+1)'(DEPTH);

  logic [2*IDX_BITS-1:0] child_mem [DEPTH];
  logic [SYM_BITS-1:0]   sym_mem [DEPTH];

  logic [2*IDX_BITS-1:0] child_q;
  logic [SYM_BITS-1:0]   sym_q;
  logic                  child_oor;
  logic                  sym_oor;

  logic wr_in, child_in, sym_in;

  assign wr_in    = {1'b0, wr.idx} < DEPTH_LIM;
  assign child_in = {1'b0, child_raddr} < DEPTH_LIM;
  assign sym_in   = {1'b0, sym_raddr} < DEPTH_LIM;

  // read-first: a read and a write to the same slot in one cycle see old data
  always_ff @(posedge clk) begin
    if (wr.en && wr_in) begin
      child_mem[AW'(wr.idx)] <= {wr.left_child, wr.right_child};
    end
    child_q   <= child_mem[AW'(child_raddr)];
    child_oor <= !child_in;
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_in) begin
      sym_mem[AW'(wr.idx)] <= wr.node_symbol;
    end
    sym_q   <= sym_mem[AW'(sym_raddr)];
    sym_oor <= !sym_in;
  end

  assign child_left  = child_oor ? '0 : child_q[2*IDX_BITS-1:IDX_BITS];
  assign child_right = child_oor ? '0 : child_q[IDX_BITS-1:0];
  assign leaf_sym    = sym_oor ? '0 : sym_q;

endmodule

// ----- rtl/core/htwd_walk.sv -----
module htwd_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_beat,
  input  htwd_pkg::in_item_t            in_item,
  input  logic [htwd_pkg::IDX_BITS-1:0] root_index,
  input  logic [htwd_pkg::IDX_BITS-1:0] leaf_count,
  input  logic [htwd_pkg::IDX_BITS-1:0] child_left,
  input  logic [htwd_pkg::IDX_BITS-1:0] child_right,
  input  logic [htwd_pkg::SYM_BITS-1:0] leaf_sym,
  output htwd_pkg::node_wr_t            wr,
  output logic [htwd_pkg::IDX_BITS-1:0] child_raddr,
  output logic [htwd_pkg::IDX_BITS-1:0] sym_raddr,
  output logic                          push,
  output htwd_pkg::out_item_t           push_item,
  output htwd_pkg::pipe_status_t        status
);
  import htwd_pkg::*;

  logic                  walk_active;
  logic [IDX_BITS-1:0]   current_node;
  logic [COUNT_BITS-1:0] total;

  // stage b: child entry read back, next node chosen
  logic b_valid, b_bit, b_eos;
  // stage c: leaf symbol read back
  logic                  c_valid, c_leaf, c_eos;
  logic [COUNT_BITS-1:0] c_count;

  logic                  dec_beat;
  logic [IDX_BITS-1:0]   next_node;
  logic                  b_leaf;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] b_count;
  logic                  walk_live;
  logic [IDX_BITS-1:0]   walk_node;

  assign dec_beat = in_beat && (in_item.command == CMD_DECODE);

  assign wr.en          = in_beat && (in_item.command == CMD_WRITE);
  assign wr.idx         = in_item.node_index;
  assign wr.left_child  = in_item.left_child;
  assign wr.right_child = in_item.right_child;
  assign wr.node_symbol = in_item.node_symbol;

  assign next_node = b_bit ? child_right : child_left;
  assign b_leaf    = next_node < leaf_count;
  assign count_inc = (total != '1) ? total + 1'b1 : total;
  assign b_count   = b_leaf ? count_inc : total;

  // forward the walk position of the bit still in stage b
  assign walk_live = b_valid ? (!b_leaf && !b_eos) : walk_active;
  assign walk_node = b_valid ? next_node : current_node;

  assign child_raddr = walk_live ? walk_node : root_index;
  assign sym_raddr   = next_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
      total       <= '0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
    end else begin
      b_valid <= dec_beat;
      c_valid <= b_valid && (b_leaf || b_eos);
      if (b_valid) begin
        total <= b_eos ? '0 : b_count;
      end
      // a node write restarts the walk, later in order than stage b
      if (wr.en) begin
        walk_active <= 1'b0;
      end else if (b_valid) begin
        walk_active <= !b_leaf && !b_eos;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_bit <= in_item.code_bit;
    b_eos <= in_item.end_of_stream;
    if (b_valid) begin
      current_node <= next_node;
    end
    c_leaf  <= b_leaf;
    c_eos   <= b_eos;
    c_count <= b_count;
  end

  assign push                   = c_valid;
  assign push_item.symbol       = c_leaf ? leaf_sym : '0;
  assign push_item.symbol_valid = c_leaf;
  assign push_item.symbol_count = c_count;
  assign push_item.stream_done  = c_eos;

  assign status.b_busy = b_valid;
  assign status.c_busy = c_valid;

endmodule

// ----- rtl/core/htwd_result_q.sv -----
module htwd_result_q (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  htwd_pkg::out_item_t                push_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output htwd_pkg::out_item_t                out_item,
  output logic [htwd_pkg::QCNT_BITS-1:0]     count
);
  import htwd_pkg::*;

  out_item_t            slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic                 pop;

  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- verif/huffman_tree_walk_decoder_test.sv -----
`timescale 1ns / 1ps

module huffman_tree_walk_decoder_test;
  import htwd_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_ROOT_INDEX;
  logic [IDX_BITS-1:0] cfg_data = '0;

  huffman_tree_walk_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the decoder state
  logic [IDX_BITS-1:0]   tree_left [512];
  logic [IDX_BITS-1:0]   tree_right [512];
  logic [SYM_BITS-1:0]   tree_sym [512];
  logic [IDX_BITS-1:0]   walk_node = '0;
  bit                    walk_on = 1'b0;
  logic [COUNT_BITS-1:0] sym_tally = '0;
  logic [IDX_BITS-1:0]   root_reg = ROOT_RESET;
  logic [IDX_BITS-1:0]   leaf_reg = LEAF_RESET;

  out_item_t symbols_due[$];
  int        fault_count = 0;
  bit        calm = 1'b0;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } probe_t;

  probe_t              probes[$];
  logic [IDX_BITS-1:0] phase_root [6];
  logic [IDX_BITS-1:0] phase_leaf [6];

  function automatic bit decode_predict(input in_item_t it, output out_item_t res);
    logic [IDX_BITS-1:0] here;
    logic [IDX_BITS-1:0] child;
    bit                  leaf;
    res = '0;
    if (it.command == CMD_WRITE) begin
      tree_left[it.node_index]  = it.left_child;
      tree_right[it.node_index] = it.right_child;
      tree_sym[it.node_index]   = it.node_symbol;
      walk_on = 1'b0;
      return 1'b0;
    end
    here  = walk_on ? walk_node : root_reg;
    child = it.code_bit ? tree_right[here] : tree_left[here];
    leaf  = child < leaf_reg;
    if (leaf) begin
      res.symbol       = tree_sym[child];
      res.symbol_valid = 1'b1;
      if (sym_tally != '1) sym_tally = sym_tally + 1'b1;
      walk_on = 1'b0;
    end else begin
      walk_node = child;
      walk_on   = 1'b1;
    end
    if (!leaf && !it.end_of_stream) return 1'b0;
    res.symbol_count = sym_tally;
    res.stream_done  = it.end_of_stream;
    // end of stream drops any partial code and restarts the count
    if (it.end_of_stream) begin
      walk_on   = 1'b0;
      walk_node = '0;
      sym_tally = '0;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t bit_in(input logic b, input logic eos);
    in_item_t it;
    it               = random_item();
    it.command       = CMD_DECODE;
    it.code_bit      = b;
    it.end_of_stream = eos;
    return it;
  endfunction

  // code bit and end flag are set high to show a write ignores them
  function automatic in_item_t node_wr(input logic [IDX_BITS-1:0] idx,
                                       input logic [IDX_BITS-1:0] l,
                                       input logic [IDX_BITS-1:0] r,
                                       input logic [SYM_BITS-1:0] s);
    in_item_t it;
    it.command       = CMD_WRITE;
    it.node_index    = idx;
    it.left_child    = l;
    it.right_child   = r;
    it.node_symbol   = s;
    it.code_bit      = 1'b1;
    it.end_of_stream = 1'b1;
    return it;
  endfunction

  // while the leaf count is not zero, half the children land on a leaf under it
  function automatic logic [IDX_BITS-1:0] pick_child();
    if (leaf_reg == 0) return IDX_BITS'($urandom_range(0, 511));
    if ($urandom_range(0, 1) == 0) return IDX_BITS'($urandom_range(0, leaf_reg - 1));
    return IDX_BITS'($urandom_range(leaf_reg, 511));
  endfunction

  function automatic in_item_t shaped_node(input logic [IDX_BITS-1:0] slot);
    in_item_t it;
    it             = random_item();
    it.command     = CMD_WRITE;
    it.node_index  = slot;
    it.left_child  = pick_child();
    it.right_child = pick_child();
    return it;
  endfunction

  function automatic out_item_t sym_res(input logic [SYM_BITS-1:0] s, input logic v,
                                        input logic [COUNT_BITS-1:0] c, input logic d);
    out_item_t o;
    o.symbol       = s;
    o.symbol_valid = v;
    o.symbol_count = c;
    o.stream_done  = d;
    return o;
  endfunction

  function automatic void add_probe(input in_item_t it, input bit typed = 1'b0,
                                    input out_item_t want = '0);
    probes.push_back('{item: it, typed: typed, want: want});
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send(input in_item_t it, input bit typed = 1'b0, input out_item_t want = '0);
    out_item_t res;
    bit        got;
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    got = decode_predict(it, res);
    if (typed) symbols_due.push_back(want);
    else if (got) symbols_due.push_back(res);
    @(negedge clk);
  endtask

  // hold the sender until every result is out and the pipeline has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [IDX_BITS-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ROOT_INDEX) root_reg = val;
    else leaf_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (symbols_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got sym %h vld %b cnt %0d done %b",
                 $time, out_item.symbol, out_item.symbol_valid, out_item.symbol_count,
                 out_item.stream_done);
        fault_count++;
      end else begin
        want = symbols_due.pop_front();
        if (out_item.symbol !== want.symbol || out_item.symbol_valid !== want.symbol_valid ||
            out_item.symbol_count !== want.symbol_count ||
            out_item.stream_done !== want.stream_done) begin
          $display("%0t: mismatch: expected sym %h vld %b cnt %0d done %b,",
                   $time, want.symbol, want.symbol_valid, want.symbol_count, want.stream_done,
                   " got sym %h vld %b cnt %0d done %b",
                   out_item.symbol, out_item.symbol_valid, out_item.symbol_count,
                   out_item.stream_done);
          fault_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int roll;

    // small tree under the reset root: 510 -> (3, 511), 511 -> (0, 255)
    add_probe(node_wr(9'd510, 9'd3, 9'd511, 8'h00));
    add_probe(node_wr(9'd3, 9'd0, 9'd0, 8'hAA));
    add_probe(node_wr(9'd511, 9'd0, 9'd255, 8'h5C));
    add_probe(node_wr(9'd0, 9'd511, 9'd511, 8'h00));
    add_probe(node_wr(9'd255, 9'd0, 9'd0, 8'hFF));
    add_probe(bit_in(1'b0, 1'b0), 1'b1, sym_res(8'hAA, 1'b1, 16'd1, 1'b0));
    add_probe(bit_in(1'b1, 1'b0));
    // end of stream landing on a leaf
    add_probe(bit_in(1'b1, 1'b1), 1'b1, sym_res(8'hFF, 1'b1, 16'd2, 1'b1));
    // end of stream mid-code, partial code dropped
    add_probe(bit_in(1'b1, 1'b1), 1'b1, sym_res(8'h00, 1'b0, 16'd0, 1'b1));
    add_probe(bit_in(1'b1, 1'b0));
    add_probe(bit_in(1'b0, 1'b0), 1'b1, sym_res(8'h00, 1'b1, 16'd1, 1'b0));
    add_probe(bit_in(1'b1, 1'b0));
    // node write mid-walk sends the next bit back to the root, count kept
    add_probe(node_wr(9'd3, 9'd0, 9'd0, 8'h3C));
    add_probe(bit_in(1'b0, 1'b0), 1'b1, sym_res(8'h3C, 1'b1, 16'd2, 1'b0));
    add_probe(bit_in(1'b1, 1'b0));
    add_probe(bit_in(1'b1, 1'b0));
    add_probe(bit_in(1'b0, 1'b1));
    add_probe(bit_in(1'b1, 1'b0));

    phase_root = '{9'd0, 9'd511, 9'd300, 9'd7, 9'd0, 9'd0};
    phase_leaf = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd1, 9'd1};
    phase_root[4] = IDX_BITS'($urandom_range(0, 511));
    phase_root[5] = IDX_BITS'($urandom_range(0, 511));
    phase_leaf[4] = IDX_BITS'($urandom_range(1, 256));
    phase_leaf[5] = IDX_BITS'($urandom_range(1, 256));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probes[k]) send(probes[k].item, probes[k].typed, probes[k].want);

    // new root while the walk sits at 511: the walk carries on from there
    write_reg(REG_ROOT_INDEX, 9'd0);
    send(bit_in(1'b1, 1'b0));
    send(bit_in(1'b0, 1'b1));

    // fill the whole table so no walk ever meets an unwritten node
    for (int s = 0; s < 512; s++) send(shaped_node(IDX_BITS'(s)));

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_ROOT_INDEX, phase_root[p]);
      write_reg(REG_LEAF_COUNT, phase_leaf[p]);
      calm = (p == 2);
      send(shaped_node(root_reg));
      for (int k = 0; k < 200; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) send(shaped_node(IDX_BITS'($urandom_range(0, 511))));
        else if (roll < 18) send(random_item());
        else send(bit_in(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0));
      end
    end

    // every bit hits a leaf
    write_reg(REG_ROOT_INDEX, 9'd300);
    write_reg(REG_LEAF_COUNT, 9'd256);
    calm = 1'b1;
    send(node_wr(9'd300, 9'd10, 9'd20, 8'h00));
    repeat (40) send(bit_in(1'($urandom_range(0, 1)), 1'b0));
    send(bit_in(1'b0, 1'b1));
    calm = 1'b0;

    settle();
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/htwd_pkg.sv
rtl/core/htwd_node_mem.sv
rtl/core/htwd_walk.sv
rtl/core/htwd_result_q.sv
rtl/core/huffman_tree_walk_decoder.sv
verif/huffman_tree_walk_decoder_test.sv
